@@ hw/rtl/cdd_pkg.sv @@
// shared types, constants and calendar functions for the date difference block
package cdd_pkg;

    // field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;

    // datapath word of the shared unit, wide enough for a signed day number difference
    localparam int WORD_W  = 28;

    // century quotient and remainder widths (year below 16384)
    localparam int CENT_W  = 8;
    localparam int REM_W   = 7;

    // multiplier operand widths
    localparam int MUL_A_W = YEAR_W;
    localparam int MUL_B_W = 13;

    // floor(y / 100) as (y * 5243) >> 19, exact for 14-bit years
    localparam logic [MUL_B_W-1:0] RECIP_100   = 13'd5243;
    localparam int                 RECIP_SHIFT = 19;
    localparam logic [MUL_B_W-1:0] DAYS_YEAR   = 13'd365;
    localparam logic [CENT_W-1:0]  CENTURY     = 8'd100;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // operations of the shared unit
    typedef enum logic [1:0] {
        OP_MUL,
        OP_ADD,
        OP_SUB
    } t_op;

    // request into the shared unit
    typedef struct packed {
        logic              en;
        t_op               op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_unit_req;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVQ,
        ST_REM,
        ST_YR,
        ST_C4,
        ST_C100,
        ST_C400,
        ST_MON,
        ST_STORE,
        ST_ORDER,
        ST_OUT
    } t_state;

    // days in a month
    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            default: len = 5'd30;
        endcase
        return len;
    endfunction

    // days in the year before the first of a month, common year
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // real calendar date check
    function automatic logic date_ok(input logic leap,
                                     input logic [MONTH_W-1:0] m,
                                     input logic [DAY_W-1:0] d);
        return (m >= 4'd1) && (m <= 4'd12) && (d >= 5'd1) && (d <= month_len(leap, m));
    endfunction

endpackage

@@ hw/rtl/cdd_unit.sv @@
// shared multiply / add / subtract unit with registered result
module cdd_unit
    import cdd_pkg::*;
(
    input  logic              i_clk,
    input  t_unit_req         i_req,
    output logic [WORD_W-1:0] o_res
);

    logic [WORD_W-1:0]          r_res;
    logic [MUL_A_W+MUL_B_W-1:0] s_prod;
    logic [WORD_W-1:0]          n_res;

    // narrow product, only the low operand bits take part
    assign s_prod = i_req.a[MUL_A_W-1:0] * i_req.b[MUL_B_W-1:0];

    // operation select
    always_comb begin
        unique case (i_req.op)
            OP_MUL:  n_res = WORD_W'(s_prod);
            OP_ADD:  n_res = i_req.a + i_req.b;
            OP_SUB:  n_res = i_req.a - i_req.b;
            default: n_res = r_res;
        endcase
    end

    // result register, loads only on a request
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

@@ hw/rtl/calendar_date_difference.sv @@
// top level: gregorian date difference sequencer around one shared arithmetic unit
//
// Takes two dates (year, month, day) and returns the absolute number of days between
// them plus a validity flag per date; the count is zero when either date is invalid
// and saturates at the 22-bit maximum. Each date's day number is built in 8 steps
// through the single shared multiply/add/subtract unit (century quotient, remainder,
// 365*year, leap corrections, month offset, store), and the store step of the second
// date also subtracts the two day numbers. One step then takes the magnitude and one
// loads the output register. The input is stalled while a word is being worked on.
// A result that is not yet taken holds the sequencer in its last step. A finished
// result waits in the output register so the next word can be taken meanwhile.
module calendar_date_difference
    import cdd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [YEAR_W-1:0]  i_first_year,
    input  logic [MONTH_W-1:0] i_first_month,
    input  logic [DAY_W-1:0]   i_first_day,
    input  logic [YEAR_W-1:0]  i_second_year,
    input  logic [MONTH_W-1:0] i_second_month,
    input  logic [DAY_W-1:0]   i_second_day,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [COUNT_W-1:0] o_day_count,
    output logic               o_first_valid,
    output logic               o_second_valid
);

    t_state             r_state, n_state;
    logic               r_sel;
    logic [YEAR_W-1:0]  r_y1, r_y2;
    logic [MONTH_W-1:0] r_m1, r_m2;
    logic [DAY_W-1:0]   r_d1, r_d2;
    logic [CENT_W-1:0]  r_c;
    logic [REM_W-1:0]   r_r;
    logic [WORD_W-1:0]  r_na, r_nb;
    logic               r_v1, r_v2;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_count;
    logic               r_fv, r_sv;

    t_unit_req          s_req;
    logic [WORD_W-1:0]  w_res;
    logic [YEAR_W-1:0]  s_y;
    logic [MONTH_W-1:0] s_m;
    logic [DAY_W-1:0]   s_d;
    logic [CENT_W-1:0]  s_c_now;
    logic               s_leap;
    logic               s_ok;
    logic [WORD_W-1:0]  s_ofs;
    logic               s_accept;
    logic               s_load;
    logic [COUNT_W-1:0] s_sat;

    cdd_unit u_unit (
        .i_clk (i_clk),
        .i_req (s_req),
        .o_res (w_res)
    );

    // date under work
    assign s_y = r_sel ? r_y2 : r_y1;
    assign s_m = r_sel ? r_m2 : r_m1;
    assign s_d = r_sel ? r_d2 : r_d1;

    // century quotient straight off the multiplier
    assign s_c_now = w_res[RECIP_SHIFT +: CENT_W];

    // leap: divisible by 4 and (not by 100 or by 400)
    assign s_leap = (s_y[1:0] == 2'd0) && ((r_r != '0) || (r_c[1:0] == 2'd0));
    assign s_ok   = date_ok(s_leap, s_m, s_d);

    // day of year, counted from zero
    assign s_ofs = WORD_W'(days_before(s_m)) + WORD_W'(s_leap && (s_m > 4'd2))
                 + WORD_W'(s_d) - WORD_W'(1);

    // handshakes
    assign s_accept = (r_state == ST_IDLE) && i_in_valid;
    assign s_load   = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);

    // saturated magnitude
    assign s_sat = (w_res[WORD_W-1:COUNT_W] != '0) ? COUNT_MAX : w_res[COUNT_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_DIVQ;
            ST_DIVQ:  n_state = ST_REM;
            ST_REM:   n_state = ST_YR;
            ST_YR:    n_state = ST_C4;
            ST_C4:    n_state = ST_C100;
            ST_C100:  n_state = ST_C400;
            ST_C400:  n_state = ST_MON;
            ST_MON:   n_state = ST_STORE;
            ST_STORE: n_state = r_sel ? ST_ORDER : ST_DIVQ;
            ST_ORDER: n_state = ST_OUT;
            ST_OUT:   if (s_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // shared unit requests
    always_comb begin
        s_req    = '0;
        s_req.op = OP_ADD;
        unique case (r_state)
            ST_DIVQ: begin
                s_req = '{en: 1'b1, op: OP_MUL, a: WORD_W'(s_y), b: WORD_W'(RECIP_100)};
            end
            ST_REM: begin
                s_req = '{en: 1'b1, op: OP_SUB, a: WORD_W'(s_y),
                          b: WORD_W'(s_c_now) * WORD_W'(CENTURY)};
            end
            ST_YR: begin
                s_req = '{en: 1'b1, op: OP_MUL, a: WORD_W'(s_y), b: WORD_W'(DAYS_YEAR)};
            end
            ST_C4: begin
                s_req = '{en: 1'b1, op: OP_ADD, a: w_res,
                          b: WORD_W'(s_y >> 2) + WORD_W'(s_y[1:0] != 2'd0)};
            end
            ST_C100: begin
                s_req = '{en: 1'b1, op: OP_SUB, a: w_res,
                          b: WORD_W'(r_c) + WORD_W'(r_r != '0)};
            end
            ST_C400: begin
                s_req = '{en: 1'b1, op: OP_ADD, a: w_res,
                          b: WORD_W'(r_c >> 2) + WORD_W'((r_c[1:0] != 2'd0) || (r_r != '0))};
            end
            ST_MON: begin
                s_req = '{en: 1'b1, op: OP_ADD, a: w_res, b: s_ofs};
            end
            ST_STORE: begin
                s_req = '{en: r_sel, op: OP_SUB, a: r_na, b: w_res};
            end
            ST_ORDER: begin
                if (w_res[WORD_W-1]) begin
                    s_req = '{en: 1'b1, op: OP_SUB, a: r_nb, b: r_na};
                end else begin
                    s_req = '{en: 1'b1, op: OP_ADD, a: w_res, b: '0};
                end
            end
            default: s_req.en = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_y1  <= i_first_year;
            r_m1  <= i_first_month;
            r_d1  <= i_first_day;
            r_y2  <= i_second_year;
            r_m2  <= i_second_month;
            r_d2  <= i_second_day;
            r_sel <= 1'b0;
        end
        if (r_state == ST_REM) begin
            r_c <= s_c_now;
        end
        if (r_state == ST_YR) begin
            r_r <= w_res[REM_W-1:0];
        end
        if (r_state == ST_MON) begin
            if (r_sel) begin
                r_v2 <= s_ok;
            end else begin
                r_v1 <= s_ok;
            end
        end
        if (r_state == ST_STORE) begin
            if (r_sel) begin
                r_nb <= w_res;
            end else begin
                r_na  <= w_res;
                r_sel <= 1'b1;
            end
        end
        if (s_load) begin
            r_count <= (r_v1 && r_v2) ? s_sat : '0;
            r_fv    <= r_v1;
            r_sv    <= r_v2;
        end
    end

    // ports
    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_day_count    = r_count;
    assign o_first_valid  = r_fv;
    assign o_second_valid = r_sv;

`ifndef ASSERT_OFF
    // an accepted word blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> o_in_stall)
        else $error("input not stalled after accept");

    // a nonzero count only comes with two valid dates
    a_count_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_day_count != '0)) |-> (o_first_valid && o_second_valid))
        else $error("nonzero count with an invalid date");

    // century remainder is in range once captured
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_C4) |-> (r_r < REM_W'(CENTURY)))
        else $error("century remainder out of range");

    // a finished result waits while the output register is still held
    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_OUT) && r_out_valid && i_out_stall) |=> (r_state == ST_OUT))
        else $error("result register overwritten while stalled");
`endif

endmodule
